/* rtl/alks_pkg.sv */
`timescale 1ns / 1ps

package alks_pkg;

	// Item action codes
	localparam logic [2:0] ACT_WR_A  = 3'd0;
	localparam logic [2:0] ACT_WR_B  = 3'd1;
	localparam logic [2:0] ACT_RD_A  = 3'd2;
	localparam logic [2:0] ACT_RD_B  = 3'd3;
	localparam logic [2:0] ACT_KEY   = 3'd4;
	localparam logic [2:0] ACT_TICK  = 3'd5;

	// Defaults and fixed limits
	localparam int KEY_COLUMNS_DEF      = 16;
	localparam int MAX_TICK_HALF_CYCLES = 7;

	// Latch bit positions
	localparam int LATCH_SOUND = 0;
	localparam int LATCH_SCAN  = 3;
	localparam int LATCH_SHIFT = 6;
	localparam int LATCH_CAPS  = 7;

	// Port read values
	localparam logic [7:0] RD_A_SCAN = 8'hff;
	localparam logic [7:0] RD_A_KEY  = 8'h80;
	localparam logic [7:0] RD_B      = 8'h3f;
	localparam logic [7:0] CA2_MASK  = 8'hfe;

	// Screen base per latch bits 5..4
	localparam logic [14:0] VBASE_0 = 15'h4000;
	localparam logic [14:0] VBASE_1 = 15'h6000;
	localparam logic [14:0] VBASE_2 = 15'h3000;
	localparam logic [14:0] VBASE_3 = 15'h5800;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture input item
		logic exec;      // apply item to state
		logic emit;      // load status result into output register
		logic step;      // load scan step result into output register
		logic sel_step;  // column read follows step column
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;   // output register can take a result
		logic tick_steps; // tick item moves the scan column
		logic last_step;  // one step left
	} sts_t;

endpackage

/* rtl/addressable_latch_keyboard_scanner.sv */
`timescale 1ns / 1ps
// Peripheral port latch and keyboard scanner.
// Input channel (in_valid/in_ready): one item per transfer; action selects
// port A write, latch write through port B, port A read, port B read,
// key change or time tick. Output channel (out_valid/out_ready): result
// items, the final one of an item flagged by last.
// Each item is captured into the item registers, applied to the state in the
// exec state, and its result is loaded into the output register in the emit
// state once the register is free. A tick that moves the scan column gives one
// result per column step (up to four), one per cycle while the output is free.
// The controller sequencer handles one item at a time; the key matrix has a
// single column read port shared by reads, CA2 and scan steps.
// A new item is taken while the previous final result still waits in the
// output register. When the receiver stalls, result generation holds until
// the output register empties; no result is dropped.
// Reset clears latch, port A and scan counter and sets row 0 of key
// columns 7, 8 and 9; the block is ready on the first cycle after reset.
module addressable_latch_keyboard_scanner #(
	parameter int KEY_COLUMNS = alks_pkg::KEY_COLUMNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  data,
	input  logic [6:0]  key_code,
	input  logic        pressed,
	input  logic [2:0]  tick_halves,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        key_seen,
	output logic        sound_strobe,
	output logic [7:0]  sound_data,
	output logic [14:0] screen_base,
	output logic        caps_lamp,
	output logic        shift_lamp,
	output logic        last
);
	import alks_pkg::*;

	cmd_t cmd;
	sts_t sts;

	alks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	alks_dp #(
		.KEY_COLUMNS (KEY_COLUMNS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (action),
		.data         (data),
		.key_code     (key_code),
		.pressed      (pressed),
		.tick_halves  (tick_halves),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data),
		.key_seen     (key_seen),
		.sound_strobe (sound_strobe),
		.sound_data   (sound_data),
		.screen_base  (screen_base),
		.caps_lamp    (caps_lamp),
		.shift_lamp   (shift_lamp),
		.last         (last)
	);

endmodule

/* rtl/alks_ctrl.sv */
`timescale 1ns / 1ps

module alks_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  alks_pkg::sts_t sts,
	output alks_pkg::cmd_t cmd
);
	import alks_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_STEP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.tick_steps ? ST_STEP : ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_STEP: begin
				cmd.sel_step = 1'b1;
				if (sts.out_free) begin
					cmd.step = 1'b1;
					if (sts.last_step) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/alks_dp.sv */
`timescale 1ns / 1ps

module alks_dp #(
	parameter int KEY_COLUMNS = alks_pkg::KEY_COLUMNS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  alks_pkg::cmd_t cmd,
	output alks_pkg::sts_t sts,
	input  logic [2:0]     action,
	input  logic [7:0]     data,
	input  logic [6:0]     key_code,
	input  logic           pressed,
	input  logic [2:0]     tick_halves,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     read_data,
	output logic           key_seen,
	output logic           sound_strobe,
	output logic [7:0]     sound_data,
	output logic [14:0]    screen_base,
	output logic           caps_lamp,
	output logic           shift_lamp,
	output logic           last
);
	import alks_pkg::*;

	localparam int IW = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1;

	// Item registers
	logic [2:0] act_q;
	logic [7:0] data_q;
	logic [6:0] key_q;
	logic       pressed_q;
	logic [2:0] half_q;

	// Architectural state
	logic [7:0] latch_q;
	logic [7:0] porta_q;
	logic [4:0] scan_q;
	logic [7:0] keys_q [KEY_COLUMNS];

	// Per-item working registers
	logic [7:0] rd_q;
	logic       strobe_q;
	logic [7:0] sdata_q;
	logic [3:0] col_q;
	logic [2:0] steps_q;

	// Output register
	logic        out_valid_q;
	logic [7:0]  out_rd_q;
	logic        out_seen_q;
	logic        out_strobe_q;
	logic [7:0]  out_sdata_q;
	logic [14:0] out_vbase_q;
	logic        out_caps_q;
	logic        out_shift_q;
	logic        out_last_q;

	logic [3:0]  cur_col;
	logic [3:0]  rd_addr;
	logic        rd_ok;
	logic [7:0]  col_bits;
	logic        ca2;
	logic [7:0]  mask;
	logic [7:0]  latch_nw;
	logic        key_ok;
	logic [2:0]  half_sat;
	logic [5:0]  scan_sum;
	logic [4:0]  steps_w;
	logic [14:0] vbase;

	// Single column read port
	assign cur_col  = latch_q[LATCH_SCAN] ? scan_q[4:1] : porta_q[3:0];
	assign rd_addr  = cmd.exec ? porta_q[3:0] : (cmd.sel_step ? col_q : cur_col);
	assign rd_ok    = ({1'b0, rd_addr} < 5'(KEY_COLUMNS));
	assign col_bits = rd_ok ? keys_q[rd_addr[IW-1:0]] : 8'h00;
	assign ca2      = |(col_bits & CA2_MASK);

	// Latch write
	assign mask     = 8'(1) << data_q[2:0];
	assign latch_nw = (latch_q & ~mask) | (data_q[3] ? mask : 8'h00);

	// Key change target
	assign key_ok = ({1'b0, key_q[3:0]} < 5'(KEY_COLUMNS));

	// Scan step count
	assign half_sat = ({1'b0, half_q} > 4'(MAX_TICK_HALF_CYCLES))
		? 3'(MAX_TICK_HALF_CYCLES) : half_q;
	assign scan_sum = {1'b0, scan_q} + {3'b000, half_sat};
	assign steps_w  = scan_sum[5:1] - {1'b0, scan_q[4:1]};

	always_comb begin
		case (latch_q[5:4])
			2'd0:    vbase = VBASE_0;
			2'd1:    vbase = VBASE_1;
			2'd2:    vbase = VBASE_2;
			default: vbase = VBASE_3;
		endcase
	end

	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.tick_steps = (act_q == ACT_TICK) && latch_q[LATCH_SCAN] && (steps_w != 5'd0);
	assign sts.last_step  = (steps_q == 3'd1);

	// Input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q     <= action;
			data_q    <= data;
			key_q     <= key_code;
			pressed_q <= pressed;
			half_q    <= tick_halves;
		end
	end

	// Control-side state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 8'h00;
			porta_q <= 8'h00;
			scan_q  <= 5'd0;
		end else if (cmd.exec) begin
			case (act_q)
				ACT_WR_A: porta_q <= data_q;
				ACT_WR_B: latch_q <= latch_nw;
				ACT_TICK: begin
					if (latch_q[LATCH_SCAN]) begin
						scan_q <= scan_sum[4:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Key matrix, one register per column
	for (genvar c = 0; c < KEY_COLUMNS; c++) begin : g_col
		localparam logic [7:0] RST = (c >= 7 && c <= 9) ? 8'h01 : 8'h00;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				keys_q[c] <= RST;
			end else if (cmd.exec && act_q == ACT_KEY && key_ok
				&& key_q[IW-1:0] == IW'(c)) begin
				keys_q[c][key_q[6:4]] <= pressed_q;
			end
		end
	end

	// Per-item results and step walk
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_q     <= 8'h00;
			strobe_q <= 1'b0;
			sdata_q  <= 8'h00;
			col_q    <= scan_q[4:1] + 4'd1;
			steps_q  <= steps_w[2:0];
			case (act_q)
				ACT_WR_B: begin
					if (latch_q[LATCH_SOUND] && !latch_nw[LATCH_SOUND]) begin
						strobe_q <= 1'b1;
						sdata_q  <= porta_q;
					end
				end
				ACT_RD_A: begin
					if (latch_q[LATCH_SCAN]) begin
						rd_q <= RD_A_SCAN;
					end else begin
						rd_q <= col_bits[porta_q[6:4]] ? RD_A_KEY : 8'h00;
					end
				end
				ACT_RD_B: rd_q <= RD_B;
				default: begin
				end
			endcase
		end else if (cmd.step) begin
			col_q   <= col_q + 4'd1;
			steps_q <= steps_q - 3'd1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.step) begin
			out_rd_q     <= cmd.emit ? rd_q : 8'h00;
			out_seen_q   <= ca2;
			out_strobe_q <= cmd.emit ? strobe_q : 1'b0;
			out_sdata_q  <= cmd.emit ? sdata_q : 8'h00;
			out_vbase_q  <= vbase;
			out_caps_q   <= latch_q[LATCH_CAPS];
			out_shift_q  <= latch_q[LATCH_SHIFT];
			out_last_q   <= cmd.emit || sts.last_step;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = out_rd_q;
	assign key_seen     = out_seen_q;
	assign sound_strobe = out_strobe_q;
	assign sound_data   = out_sdata_q;
	assign screen_base  = out_vbase_q;
	assign caps_lamp    = out_caps_q;
	assign shift_lamp   = out_shift_q;
	assign last         = out_last_q;

endmodule

/* rtl/alks_checker.sv */
`timescale 1ns / 1ps

module alks_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  read_data,
	input logic        sound_strobe,
	input logic [7:0]  sound_data,
	input logic [14:0] screen_base
);
	import alks_pkg::*;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("result changed while stalled");

	// One item at a time: a transfer closes the input side
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while item in work");

	// Read data is one of the port values
	a_rd_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> read_data == 8'h00 || read_data == RD_A_KEY
			|| read_data == RD_A_SCAN || read_data == RD_B)
		else $error("bad read data");

	// Sound byte only with strobe
	a_sound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sound_strobe |-> sound_data == 8'h00)
		else $error("sound data without strobe");

	// Screen base is one of four
	a_vbase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> screen_base == VBASE_0 || screen_base == VBASE_1
			|| screen_base == VBASE_2 || screen_base == VBASE_3)
		else $error("bad screen base");

endmodule

bind addressable_latch_keyboard_scanner alks_checker u_alks_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.read_data    (read_data),
	.sound_strobe (sound_strobe),
	.sound_data   (sound_data),
	.screen_base  (screen_base)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps

import alks_pkg::*;

// Action codes the block decodes as no-ops
localparam logic [2:0] ACT_SPARE_6 = 3'd6;
localparam logic [2:0] ACT_SPARE_7 = 3'd7;

// A tick reports at most this many column steps
localparam int MAX_STEP_RESULTS = 4;

typedef struct packed {
	logic [7:0]  rd;
	logic        seen;
	logic        strobe;
	logic [7:0]  sdata;
	logic [14:0] vbase;
	logic        caps;
	logic        shift;
	logic        is_last;
} port_result_t;

// Tracks the port and keyboard state and the results it owes
class port_scoreboard;
	logic [7:0]   latch;
	logic [7:0]   port_a;
	logic [7:0]   keys [16];
	logic [4:0]   scan_cnt;
	port_result_t owed_q [$];
	int           errors;

	function new();
		latch    = '0;
		port_a   = '0;
		scan_cnt = '0;
		foreach (keys[c]) keys[c] = '0;
		// Row 0 of columns 7..9 reads as down after reset
		for (int c = 7; c <= 9; c++) keys[c][0] = 1'b1;
		errors = 0;
	endfunction

	function logic ca2_of(logic [3:0] col);
		return |(keys[col] & CA2_MASK);
	endfunction

	function logic [3:0] scan_column();
		return latch[LATCH_SCAN] ? scan_cnt[4:1] : port_a[3:0];
	endfunction

	function void owe(logic [7:0] rd, logic seen, logic strobe, logic [7:0] sdata,
			logic is_last);
		port_result_t r;
		r.rd      = rd;
		r.seen    = seen;
		r.strobe  = strobe;
		r.sdata   = sdata;
		case (latch[5:4])
			2'd0: r.vbase = VBASE_0;
			2'd1: r.vbase = VBASE_1;
			2'd2: r.vbase = VBASE_2;
			default: r.vbase = VBASE_3;
		endcase
		r.caps    = latch[LATCH_CAPS];
		r.shift   = latch[LATCH_SHIFT];
		r.is_last = is_last;
		owed_q.push_back(r);
	endfunction

	// Apply one accepted item and queue the results it produces
	function void note_item(logic [2:0] act, logic [7:0] d, logic [6:0] kc, logic pr,
			logic [2:0] hc);
		logic [7:0] rd;
		logic       strobe;
		logic [7:0] sdata;
		logic [7:0] prev_latch;
		int         start, half, steps;
		rd     = '0;
		strobe = 1'b0;
		sdata  = '0;
		case (act)
			ACT_WR_A: port_a = d;
			ACT_WR_B: begin
				prev_latch = latch;
				latch[d[2:0]] = d[3];
				// sound chip strobe on falling latch bit 0
				if (prev_latch[LATCH_SOUND] && !latch[LATCH_SOUND]) begin
					strobe = 1'b1;
					sdata  = port_a;
				end
			end
			ACT_RD_A: begin
				if (latch[LATCH_SCAN])
					rd = RD_A_SCAN;
				else
					rd = keys[port_a[3:0]][port_a[6:4]] ? RD_A_KEY : 8'h00;
			end
			ACT_RD_B: rd = RD_B;
			ACT_KEY: keys[kc[3:0]][kc[6:4]] = pr;
			ACT_TICK: begin
				if (latch[LATCH_SCAN]) begin
					start = scan_cnt;
					half  = (hc > MAX_TICK_HALF_CYCLES) ? MAX_TICK_HALF_CYCLES : hc;
					steps = ((start + half) >> 1) - (start >> 1);
					for (int k = 1; k <= steps; k++)
						if (k + MAX_STEP_RESULTS > steps)
							owe(8'h00, ca2_of(4'((start >> 1) + k)), 1'b0, 8'h00, k == steps);
					scan_cnt = 5'(start + half);
					if (steps > 0)
						return;
				end
			end
			default: ;
		endcase
		owe(rd, ca2_of(scan_column()), strobe, sdata, 1'b1);
	endfunction

	function void cmp_field(string fname, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, want, got);
			errors++;
		end
	endfunction

	// Compare one result transfer against the oldest owed result
	function void check_result(port_result_t got);
		port_result_t want;
		if (owed_q.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual %h", $time, got);
			errors++;
			return;
		end
		want = owed_q.pop_front();
		cmp_field("read_data", want.rd, got.rd);
		cmp_field("key_seen", want.seen, got.seen);
		cmp_field("sound_strobe", want.strobe, got.strobe);
		cmp_field("sound_data", want.sdata, got.sdata);
		cmp_field("screen_base", want.vbase, got.vbase);
		cmp_field("caps_lamp", want.caps, got.caps);
		cmp_field("shift_lamp", want.shift, got.shift);
		cmp_field("last", want.is_last, got.is_last);
	endfunction
endclass

module testbench;

	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = '0;
	logic [7:0]  data = '0;
	logic [6:0]  key_code = '0;
	logic        pressed = 1'b0;
	logic [2:0]  tick_halves = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  read_data;
	logic        key_seen;
	logic        sound_strobe;
	logic [7:0]  sound_data;
	logic [14:0] screen_base;
	logic        caps_lamp;
	logic        shift_lamp;
	logic        last;

	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	port_scoreboard sb;

	addressable_latch_keyboard_scanner uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .data(data), .key_code(key_code), .pressed(pressed),
		.tick_halves(tick_halves),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .key_seen(key_seen), .sound_strobe(sound_strobe),
		.sound_data(sound_data), .screen_base(screen_base), .caps_lamp(caps_lamp),
		.shift_lamp(shift_lamp), .last(last)
	);

	always #1 clk = ~clk;

	// Offer one item, optionally after an idle burst, and wait for its transfer
	task automatic send_item(input logic [2:0] act, input logic [7:0] d,
			input logic [6:0] kc, input logic pr, input logic [2:0] hc);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		data        <= d;
		key_code    <= kc;
		pressed     <= pr;
		tick_halves <= hc;
		do @(posedge clk); while (!in_ready);
		sb.note_item(act, d, kc, pr, hc);
	endtask

	// Weighted mix: scanning is kept on often so ticks step columns
	task automatic send_random();
		int         pick;
		logic [7:0] d;
		logic [2:0] act;
		pick = $urandom_range(0, 99);
		d    = 8'($urandom);
		if (pick < 18)
			act = ACT_WR_A;
		else if (pick < 38) begin
			act = ACT_WR_B;
			// bias toward switching scan mode on
			if ($urandom_range(0, 2) == 0)
				d = {d[7:4], 1'b1, 3'(LATCH_SCAN)};
		end else if (pick < 48)
			act = ACT_RD_A;
		else if (pick < 53)
			act = ACT_RD_B;
		else if (pick < 73)
			act = ACT_KEY;
		else if (pick < 96)
			act = ACT_TICK;
		else
			act = pick[0] ? ACT_SPARE_6 : ACT_SPARE_7;
		send_item(act, d, 7'($urandom), $urandom_range(0, 9) < 6,
			3'($urandom_range(0, 7)));
	endtask

	// Result side: stall bursts, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({read_data, key_seen, sound_strobe, sound_data, screen_base,
				caps_lamp, shift_lamp, last});
	end

	// Main sequence
	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Port reads and key reporting, not scanning
		send_item(ACT_RD_B, 8'h00, 7'h00, 1'b0, 3'd0);
		send_item(ACT_RD_A, 8'h00, 7'h00, 1'b0, 3'd0);
		send_item(ACT_WR_A, 8'h07, 7'h00, 1'b0, 3'd0);
		send_item(ACT_RD_A, 8'h00, 7'h00, 1'b0, 3'd0);
		send_item(ACT_KEY, 8'h00, 7'h7f, 1'b1, 3'd0);
		send_item(ACT_WR_A, 8'hff, 7'h00, 1'b0, 3'd0);
		send_item(ACT_RD_A, 8'h00, 7'h00, 1'b0, 3'd0);
		send_item(ACT_KEY, 8'h00, 7'h00, 1'b0, 3'd0);
		send_item(ACT_KEY, 8'h00, 7'h17, 1'b1, 3'd0);
		// Sound strobe on falling latch bit 0
		send_item(ACT_WR_B, 8'h08, 7'h00, 1'b0, 3'd0);
		send_item(ACT_WR_B, 8'h00, 7'h00, 1'b0, 3'd0);
		// Video base and LED bits
		send_item(ACT_WR_B, 8'h0c, 7'h00, 1'b0, 3'd0);
		send_item(ACT_WR_B, 8'h0d, 7'h00, 1'b0, 3'd0);
		send_item(ACT_WR_B, 8'h0e, 7'h00, 1'b0, 3'd0);
		send_item(ACT_WR_B, 8'hff, 7'h00, 1'b0, 3'd0);
		send_item(ACT_WR_B, 8'h05, 7'h00, 1'b0, 3'd0);
		// Tick while not scanning leaves the counter alone
		send_item(ACT_TICK, 8'h00, 7'h00, 1'b0, 3'd7);
		// Scanning: no step, zero steps, then four steps
		send_item(ACT_WR_B, 8'h0b, 7'h00, 1'b0, 3'd0);
		send_item(ACT_TICK, 8'h00, 7'h00, 1'b0, 3'd0);
		send_item(ACT_TICK, 8'h00, 7'h00, 1'b0, 3'd1);
		send_item(ACT_TICK, 8'h00, 7'h00, 1'b0, 3'd7);
		send_item(ACT_RD_A, 8'h00, 7'h00, 1'b0, 3'd0);
		// Unused action codes
		send_item(ACT_SPARE_6, 8'h00, 7'h00, 1'b0, 3'd0);
		send_item(ACT_SPARE_7, 8'hff, 7'h7f, 1'b1, 3'd7);
		send_item(ACT_TICK, 8'h00, 7'h00, 1'b0, 3'd6);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 150)
				hold_req = 1'b1;
			if (i == 330)
				idle_on = 1'b0;
			send_random();
		end
		in_valid <= 1'b0;

		while (sb.owed_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS addressable_latch_keyboard_scanner");
		else
			$display("FAIL addressable_latch_keyboard_scanner");
		$finish;
	end

	// Run limit
	initial begin
		#1000000;
		$display("FAIL addressable_latch_keyboard_scanner");
		$finish;
	end

endmodule
